// ----- rtl/core/siphash_2_4_stream_hasher_core_assert.svh -----
// assertion macros used by the hasher checker
`ifndef SIPHASH_2_4_STREAM_HASHER_CORE_ASSERT_SVH
`define SIPHASH_2_4_STREAM_HASHER_CORE_ASSERT_SVH

// same-cycle implication
`define SIP24_ASSERT_NOW(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("sip24 check failed (same cycle)");

// next-cycle implication
`define SIP24_ASSERT_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sip24 check failed (next cycle)");

`endif

// ----- rtl/core/sip24_pkg.sv -----
// shared types, constants and round function of the siphash-2-4 hasher
`default_nettype none

package sip24_pkg;

  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 4;
  localparam int LEN_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 128;
  localparam int FIN_CNT_W = 3;

  localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] TWEAK_WIDE = 64'h00000000000000ee;
  localparam logic [WORD_W-1:0] TWEAK_NARROW = 64'h00000000000000ff;
  localparam logic [WORD_W-1:0] TWEAK_HIGH = 64'h00000000000000dd;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;
  localparam logic [FIN_CNT_W-1:0] FIN_LOW_LAST = 3'd3;
  localparam logic [FIN_CNT_W-1:0] FIN_HIGH_LAST = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_OUTPUT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND2,
    ST_LEN1,
    ST_LEN2,
    ST_FIN,
    ST_PUBLISH
  } ctrl_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } sip_state_t;

  typedef struct packed {
    logic load;
    logic round_en;
    logic xor_d_m;
    logic xor_a_m;
    logic xor_c_fin;
    logic xor_b_dd;
    logic set_len_blk;
    logic cap_low;
    logic cap_high;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_full;
    logic blk_last;
    logic wide;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
    a = s.a + s.b;
    b = rotl(s.b, 13) ^ a;
    a = rotl(a, 32);
    c = s.c + s.d;
    d = rotl(s.d, 16) ^ c;
    a = a + d;
    d = rotl(d, 21) ^ a;
    c = c + b;
    b = rotl(b, 17) ^ c;
    c = rotl(c, 32);
    sip_round = '{a: a, b: b, c: c, d: d};
  endfunction

  function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
    logic [WORD_W-1:0] mask;
    mask = '0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      if (COUNT_W'(i) < count) begin
        mask[i*8 +: 8] = 8'hff;
      end
    end
    byte_mask = mask;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sip24_dp.sv -----
// datapath: key registers, sip state, round unit, block forming and tag registers
`default_nettype none

module sip24_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [sip24_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sip24_pkg::WORD_W-1:0]         cfg_data,
  input  wire logic [sip24_pkg::WORD_W-1:0]         message_word,
  input  wire logic [sip24_pkg::COUNT_W-1:0]        byte_count,
  input  wire logic                                 end_of_message,
  input  wire sip24_pkg::dp_cmd_t                   cmd,
  output      sip24_pkg::dp_status_t                status,
  output      logic [sip24_pkg::WORD_W-1:0]         hash_low,
  output      logic [sip24_pkg::WORD_W-1:0]         hash_high
);

  logic [sip24_pkg::WORD_W-1:0] key_low;
  logic [sip24_pkg::WORD_W-1:0] key_high;
  logic                         wide_output;

  sip24_pkg::sip_state_t        st;
  logic [sip24_pkg::WORD_W-1:0] m_q;
  logic [sip24_pkg::LEN_W-1:0]  len_q;
  logic [sip24_pkg::LEN_W-1:0]  len_blk;
  logic                         start_q;
  logic                         full_q;
  logic                         last_q;
  logic [sip24_pkg::WORD_W-1:0] tag_low;
  logic [sip24_pkg::WORD_W-1:0] tag_high;

  logic [sip24_pkg::COUNT_W-1:0] count_clamped;
  logic                          in_full;
  logic [sip24_pkg::LEN_W-1:0]   len_new;
  logic [sip24_pkg::WORD_W-1:0]  m_in;
  logic [sip24_pkg::WORD_W-1:0]  m_use;
  logic [sip24_pkg::WORD_W-1:0]  fin_tweak;
  sip24_pkg::sip_state_t         init_st;
  sip24_pkg::sip_state_t         pre;
  sip24_pkg::sip_state_t         rnd;
  sip24_pkg::sip_state_t         post;
  logic [sip24_pkg::WORD_W-1:0]  rnd_fold;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      wide_output <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sip24_pkg::REG_KEY_LOW:     key_low <= cfg_data;
        sip24_pkg::REG_KEY_HIGH:    key_high <= cfg_data;
        sip24_pkg::REG_WIDE_OUTPUT: wide_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // block forming
  always_comb begin
    in_full = byte_count >= sip24_pkg::FULL_COUNT;
    count_clamped = in_full ? sip24_pkg::FULL_COUNT : byte_count;
    len_new = (start_q ? '0 : len_q) + sip24_pkg::LEN_W'(count_clamped);
    if (in_full) begin
      m_in = message_word;
    end else begin
      m_in = (message_word & sip24_pkg::byte_mask(count_clamped)) | {len_new, 56'd0};
    end
  end

  // round unit
  always_comb begin
    init_st.a = sip24_pkg::SIP_C0 ^ key_low;
    init_st.b = sip24_pkg::SIP_C1 ^ key_high ^ (wide_output ? sip24_pkg::TWEAK_WIDE : '0);
    init_st.c = sip24_pkg::SIP_C2 ^ key_low;
    init_st.d = sip24_pkg::SIP_C3 ^ key_high;
    fin_tweak = wide_output ? sip24_pkg::TWEAK_WIDE : sip24_pkg::TWEAK_NARROW;
    m_use = cmd.load ? m_in : m_q;
    pre = (cmd.load && start_q) ? init_st : st;
    if (cmd.xor_d_m) begin
      pre.d = pre.d ^ m_use;
    end
    rnd = sip24_pkg::sip_round(pre);
    rnd_fold = rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;
    post = rnd;
    if (cmd.xor_a_m) begin
      post.a = post.a ^ m_q;
    end
    if (cmd.xor_c_fin) begin
      post.c = post.c ^ fin_tweak;
    end
    if (cmd.xor_b_dd) begin
      post.b = post.b ^ sip24_pkg::TWEAK_HIGH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_q <= 1'b1;
      len_q <= '0;
    end else if (cmd.load) begin
      start_q <= !in_full || end_of_message;
      len_q <= (!in_full || end_of_message) ? '0 : len_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_en) begin
      st <= post;
    end
    if (cmd.load) begin
      m_q <= m_in;
      len_blk <= len_new;
      full_q <= in_full;
      last_q <= end_of_message;
    end else if (cmd.set_len_blk) begin
      m_q <= {len_blk, 56'd0};
    end
    if (cmd.cap_low) begin
      tag_low <= rnd_fold;
      tag_high <= '0;
    end
    if (cmd.cap_high) begin
      tag_high <= rnd_fold;
    end
    if (cmd.publish) begin
      hash_low <= tag_low;
      hash_high <= tag_high;
    end
  end

  assign status = '{blk_full: full_q, blk_last: last_q, wide: wide_output};

endmodule

`default_nettype wire

// ----- rtl/core/sip24_ctrl.sv -----
// controller: sequences compression, length block, finalization and result handoff
`default_nettype none

module sip24_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire sip24_pkg::dp_status_t status,
  output      sip24_pkg::dp_cmd_t    cmd
);

  sip24_pkg::ctrl_state_t             state;
  sip24_pkg::ctrl_state_t             state_next;
  logic [sip24_pkg::FIN_CNT_W-1:0]    fin_cnt;
  logic [sip24_pkg::FIN_CNT_W-1:0]    fin_cnt_next;
  logic                               out_valid;
  logic                               out_valid_next;
  logic                               can_publish;

  assign can_publish = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sip24_pkg::ST_IDLE;
      fin_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fin_cnt <= fin_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sip24_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = sip24_pkg::ST_ROUND2;
        end
      end
      sip24_pkg::ST_ROUND2: begin
        priority if (status.blk_full && !status.blk_last) begin
          state_next = sip24_pkg::ST_IDLE;
        end else if (status.blk_full) begin
          state_next = sip24_pkg::ST_LEN1;
        end else begin
          state_next = sip24_pkg::ST_FIN;
        end
      end
      sip24_pkg::ST_LEN1: state_next = sip24_pkg::ST_LEN2;
      sip24_pkg::ST_LEN2: state_next = sip24_pkg::ST_FIN;
      sip24_pkg::ST_FIN: begin
        if ((fin_cnt == sip24_pkg::FIN_LOW_LAST && !status.wide) ||
            fin_cnt == sip24_pkg::FIN_HIGH_LAST) begin
          state_next = sip24_pkg::ST_PUBLISH;
        end
      end
      sip24_pkg::ST_PUBLISH: begin
        if (can_publish) begin
          state_next = sip24_pkg::ST_IDLE;
        end
      end
      default: state_next = sip24_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    s_tready = 1'b0;
    fin_cnt_next = '0;
    unique case (state)
      sip24_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        cmd.round_en = s_tvalid;
        cmd.xor_d_m = s_tvalid;
      end
      sip24_pkg::ST_ROUND2: begin
        cmd.round_en = 1'b1;
        cmd.xor_a_m = 1'b1;
        cmd.xor_c_fin = !status.blk_full;
        cmd.set_len_blk = status.blk_full && status.blk_last;
      end
      sip24_pkg::ST_LEN1: begin
        cmd.round_en = 1'b1;
        cmd.xor_d_m = 1'b1;
      end
      sip24_pkg::ST_LEN2: begin
        cmd.round_en = 1'b1;
        cmd.xor_a_m = 1'b1;
        cmd.xor_c_fin = 1'b1;
      end
      sip24_pkg::ST_FIN: begin
        cmd.round_en = 1'b1;
        fin_cnt_next = fin_cnt + sip24_pkg::FIN_CNT_W'(1);
        if (fin_cnt == sip24_pkg::FIN_LOW_LAST) begin
          cmd.cap_low = 1'b1;
          cmd.xor_b_dd = status.wide;
        end
        cmd.cap_high = fin_cnt == sip24_pkg::FIN_HIGH_LAST;
      end
      sip24_pkg::ST_PUBLISH: begin
        cmd.publish = can_publish;
      end
      default: ;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/siphash_2_4_stream_hasher_core.sv -----
// top level of the siphash-2-4 stream hasher
// a full word that is not last gets one round in the accept cycle and one in ST_ROUND2
// a last item gets the same two rounds, then the length-block rounds in ST_LEN1 and ST_LEN2
// when its byte count is 8 or more, then 4 finalization rounds (8 rounds in wide mode) and
// the handoff in ST_PUBLISH; one round unit, one round per cycle, one item in work at a time
// the finished tag waits in an output register while the next item is taken
// rst (synchronous) clears keys, mode, length and control; the next item starts a message
`default_nettype none

module siphash_2_4_stream_hasher_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  input  wire logic [sip24_pkg::S_DATA_W-1:0]       s_tdata,  // message_word, byte_count
  input  wire logic                                 s_tlast,
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  output      logic [sip24_pkg::M_DATA_W-1:0]       m_tdata,  // hash_low, hash_high
  input  wire logic                                 cfg_we,
  input  wire logic [sip24_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sip24_pkg::WORD_W-1:0]         cfg_data
);

  sip24_pkg::dp_cmd_t           cmd;
  sip24_pkg::dp_status_t        status;
  logic [sip24_pkg::WORD_W-1:0] hash_low;
  logic [sip24_pkg::WORD_W-1:0] hash_high;

  sip24_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sip24_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .message_word   (s_tdata[63:0]),
    .byte_count     (s_tdata[67:64]),
    .end_of_message (s_tlast),
    .cmd            (cmd),
    .status         (status),
    .hash_low       (hash_low),
    .hash_high      (hash_high)
  );

  assign m_tdata = {hash_high, hash_low};

endmodule

`default_nettype wire

// ----- rtl/core/sip24_chk.sv -----
// port-level checker for the hasher and its bind
`default_nettype none

`include "siphash_2_4_stream_hasher_core_assert.svh"

module sip24_chk (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [sip24_pkg::M_DATA_W-1:0]    m_tdata
);

  `SIP24_ASSERT_NEXT(a_reset_idle, clk, rst, s_tready && !m_tvalid)
  `SIP24_ASSERT_NEXT(a_out_hold, clk, !rst && m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SIP24_ASSERT_NEXT(a_busy_after_item, clk, !rst && s_tvalid && s_tready, !s_tready)
  `SIP24_ASSERT_NOW(a_no_tag_while_ready, clk, !rst && $rose(m_tvalid), $past(!s_tready))

endmodule

bind siphash_2_4_stream_hasher_core sip24_chk u_sip24_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
